// ===== rtl/core/aes128_block_cipher_core_defines.svh =====
// Assertion macros for the AES-128 core.
`ifndef AES128_BLOCK_CIPHER_CORE_DEFINES_SVH
`define AES128_BLOCK_CIPHER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/core/aes_pkg.sv =====
// Package with AES types, S-box tables and GF(2^8) helpers.
`timescale 1ns / 1ps
package aes_pkg;
    localparam int NUM_ROUNDS = 10;
    localparam int REG_KEY_HIGH = 0;
    localparam int REG_KEY_LOW = 1;
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic   dec;
        t_block data;
    } t_item;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tab [256];
        tab = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tab[x];
    endfunction

    function automatic logic [7:0] rev_sbox(input logic [7:0] x);
        logic [7:0] tab [256];
        tab = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return tab[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] o;
        for (int i = 0; i < 4; i++) begin
            a[i] = c[31-8*i -: 8];
            x2[i] = xt(a[i]);
            x4[i] = xt(x2[i]);
            x8[i] = xt(x4[i]);
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        for (int r = 0; r < 4; r++) begin
            o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
        end
        return o;
    endfunction

    function automatic logic [7:0] byte_at(input t_block s, input int i);
        return s[127-8*i -: 8];
    endfunction
endpackage

// ===== rtl/core/aes_stream_if.sv =====
// Valid/ready stream interface carrying an item payload.
`timescale 1ns / 1ps
interface aes_stream_if #(parameter int W = 129);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/aes_cfg_if.sv =====
// Configuration write interface with register index and data.
`timescale 1ns / 1ps
interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/aes_key_sched.sv =====
// Key schedule: all round keys from the key registers, recomputed on key writes.
`timescale 1ns / 1ps
module aes_key_sched
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic [127:0] i_key,
    output t_block       o_rk [NUM_ROUNDS+1]
);
    t_block r_rk [NUM_ROUNDS+1];

    assign o_rk[0] = i_key;
    for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_rk
        logic [31:0] w0, w1, w2, w3, t;
        always_comb begin
            t = {sbox(r_rk[r-1][23:16]) ^ rcon(4'(r)), sbox(r_rk[r-1][15:8]),
                 sbox(r_rk[r-1][7:0]), sbox(r_rk[r-1][31:24])};
            w0 = r_rk[r-1][127:96] ^ t;
            w1 = r_rk[r-1][95:64] ^ w0;
            w2 = r_rk[r-1][63:32] ^ w1;
            w3 = r_rk[r-1][31:0] ^ w2;
        end
        always_ff @(posedge i_clk) begin
            r_rk[r] <= {w0, w1, w2, w3};
        end
        assign o_rk[r] = r_rk[r];
    end
    always_ff @(posedge i_clk) begin
        r_rk[0] <= i_key;
    end
endmodule

// ===== rtl/core/aes_round.sv =====
// One registered cipher round, forward or inverse, with its pipeline valid bit.
`timescale 1ns / 1ps
module aes_round
    import aes_pkg::*;
#(
    parameter int RND = 1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_item  i_item,
    input  t_block i_enc_key,
    input  t_block i_dec_key,
    output logic   o_valid,
    output t_item  o_item
);
    localparam bit LAST = (RND == NUM_ROUNDS);
    logic   r_valid;
    t_item  r_item;
    t_block sf, rf, mf, ri, si, ki, n_data;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sf[127-8*(4*c+r) -: 8] = sbox(byte_at(i_item.data, 4*((c+r)%4)+r));
                ri[127-8*(4*((c+r)%4)+r) -: 8] = byte_at(i_item.data, 4*c+r);
            end
        end
        rf = sf;
        for (int c = 0; c < 4; c++) begin
            mf[127-32*c -: 32] = LAST ? rf[127-32*c -: 32] : mix_col(rf[127-32*c -: 32]);
        end
        for (int i = 0; i < 16; i++) begin
            si[127-8*i -: 8] = rev_sbox(byte_at(ri, i));
        end
        ki = si ^ i_dec_key;
        if (i_item.dec == CMD_DEC) begin
            n_data = ki;
            if (!LAST) begin
                for (int c = 0; c < 4; c++) begin
                    n_data[127-32*c -: 32] = inv_mix_col(ki[127-32*c -: 32]);
                end
            end
        end else begin
            n_data = mf ^ i_enc_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= '{dec: i_item.dec, data: n_data};
        end
    end
    assign o_valid = r_valid;
    assign o_item = r_item;
endmodule

// ===== rtl/core/aes128_block_cipher_core.sv =====
// AES-128 core: one initial key stage and ten round stages, the last drives the result.
// Pipeline: 11 register stages between an accepted item and its result.
// Throughput: one item per cycle; the whole pipeline advances together when the
// last stage is empty or being taken, so a stall holds every stage.
// Reset: synchronous active low; clears valid bits and zeroes both key registers.
// After reset and after every key write, input is held off until the settle counter reaches zero.
`timescale 1ns / 1ps
`include "aes128_block_cipher_core_defines.svh"
module aes128_block_cipher_core
    import aes_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    aes_stream_if.sink      s_in,
    aes_stream_if.source    m_out,
    aes_cfg_if.sink         s_cfg
);
    localparam logic [3:0] KEY_SETTLE = 4'(NUM_ROUNDS + 1);

    logic [63:0] r_key_high, r_key_low;
    logic [3:0]  r_settle;
    t_block      rk [NUM_ROUNDS+1];
    logic        v [NUM_ROUNDS+1];
    t_item       it [NUM_ROUNDS+1];
    t_item       in_item;
    logic        en, in_acc, r_v0;
    t_item       r_it0;

    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low <= '0;
        end else if (s_cfg.valid) begin
            if (s_cfg.index == 1'(REG_KEY_HIGH)) begin
                r_key_high <= s_cfg.wdata;
            end else begin
                r_key_low <= s_cfg.wdata;
            end
        end
    end

    // The round keys ripple through the registered schedule one stage per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= KEY_SETTLE;
        end else if (s_cfg.valid && s_cfg.ready) begin
            r_settle <= KEY_SETTLE;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 4'd1;
        end
    end

    aes_key_sched u_ks (.i_clk(i_clk), .i_key({r_key_high, r_key_low}), .o_rk(rk));

    assign en = !m_out.valid || m_out.ready;
    assign s_in.ready = en && (r_settle == '0);
    assign in_acc = s_in.valid && s_in.ready;
    assign in_item = s_in.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= in_acc;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it0.dec <= in_item.dec;
            r_it0.data <= in_item.data ^ (in_item.dec ? rk[NUM_ROUNDS] : rk[0]);
        end
    end
    assign v[0] = r_v0;
    assign it[0] = r_it0;

    for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_rnd
        aes_round #(.RND(r)) u_round (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(v[r-1]), .i_item(it[r-1]),
            .i_enc_key(rk[r]), .i_dec_key(rk[NUM_ROUNDS-r]),
            .o_valid(v[r]), .o_item(it[r])
        );
    end

    assign m_out.valid = v[NUM_ROUNDS];
    assign m_out.data = it[NUM_ROUNDS].data;

    `AES_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready, m_out.valid && $stable(m_out.data), "stall")
    `AES_ASSERT_NEXT(a_front_move, i_clk, i_rst_n, s_in.valid && s_in.ready, r_v0, "front")
    `AES_ASSERT(a_ready_en, i_clk, i_rst_n, !s_in.ready || en, "ready while stalled")
    `AES_ASSERT(a_settle_hold, i_clk, i_rst_n, !s_in.ready || (r_settle == '0), "settle")
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the AES-128 core: key phases with directed and random blocks.
`timescale 1ns / 1ps
module tb;
    import aes_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [7:0] AFFINE_C = 8'h63;
    localparam logic [7:0] POLY_LOW = 8'h1b;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_cipher_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aes_stream_if #(.W($bits(t_item))) in_if ();
    aes_stream_if #(.W($bits(t_block))) out_if ();
    aes_cfg_if cfg_if ();

    aes128_block_cipher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if.sink),
        .m_out   (out_if.source),
        .s_cfg   (cfg_if.sink)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    logic [7:0] fwd_sub [256];
    logic [7:0] rev_sub [256];
    logic [127:0] cur_key = '0;
    t_item block_queue [$];
    t_cipher_out cipher_queue [$];
    int err_cnt = 0;
    int idle_cnt = 0;

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= x;
            x = gf_dbl(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic t_cipher_out aes_predict(input logic dec, input logic [127:0] blk,
                                                input logic [127:0] key);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] w4 [4];
        logic [7:0] col [4];
        logic [7:0] coef [4];
        logic [7:0] x;
        logic [7:0] rc;
        int rnd;
        t_cipher_out res;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127-8*i -: 8];
            st[i] = blk[127-8*i -: 8];
        end
        rc = 8'h01;
        for (int w = 4; w < 44; w++) begin
            for (int j = 0; j < 4; j++) w4[j] = rk[4*(w-1)+j];
            if (w % 4 == 0) begin
                x = w4[0];
                w4[0] = fwd_sub[w4[1]] ^ rc;
                w4[1] = fwd_sub[w4[2]];
                w4[2] = fwd_sub[w4[3]];
                w4[3] = fwd_sub[x];
                rc = gf_dbl(rc);
            end
            for (int j = 0; j < 4; j++) rk[4*w+j] = rk[4*(w-4)+j] ^ w4[j];
        end
        if (dec) begin
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        rnd = dec ? 10 : 0;
        for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd+i];
        for (int step = 1; step <= 10; step++) begin
            rnd = dec ? 10 - step : step;
            tmp = st;
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    if (dec) st[4*((c+r)%4)+r] = rev_sub[tmp[4*c+r]];
                    else st[4*c+r] = fwd_sub[tmp[4*((c+r)%4)+r]];
                end
            end
            if (!dec && step < 10) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
                    for (int r = 0; r < 4; r++) begin
                        st[4*c+r] = gf_mul(coef[0], col[r]) ^ gf_mul(coef[1], col[(r+1)%4]) ^
                                    gf_mul(coef[2], col[(r+2)%4]) ^ gf_mul(coef[3], col[(r+3)%4]);
                    end
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd+i];
            if (dec && step < 10) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
                    for (int r = 0; r < 4; r++) begin
                        st[4*c+r] = gf_mul(coef[0], col[r]) ^ gf_mul(coef[1], col[(r+1)%4]) ^
                                    gf_mul(coef[2], col[(r+2)%4]) ^ gf_mul(coef[3], col[(r+3)%4]);
                    end
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.hi[63-8*i -: 8] = st[i];
            res.lo[63-8*i -: 8] = st[8+i];
        end
        return res;
    endfunction

    initial begin : build_sbox
        logic [7:0] inv;
        logic [7:0] b;
        for (int v = 0; v < 256; v++) begin
            inv = '0;
            for (int y = 1; y < 256; y++) begin
                if (gf_mul(v[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            end
            b = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ AFFINE_C;
            fwd_sub[v] = b;
            rev_sub[b] = v[7:0];
        end
    end

    // Block driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            nxt_valid = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                cipher_queue.push_back(aes_predict(block_queue[0].dec, block_queue[0].data,
                                                   cur_key));
                void'(block_queue.pop_front());
                nxt_valid = 1'b0;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else if (!in_if.valid && gap_left > 0) begin
                gap_left <= gap_left - 1;
            end
            if (!nxt_valid && block_queue.size() > 0 &&
                (gap_left == 0 || (in_if.valid && in_if.ready && burst_left > 1))) begin
                nxt_valid = 1'b1;
            end
            in_if.valid <= nxt_valid;
            if (nxt_valid) in_if.data <= block_queue[0];
        end
    end

    // Result monitor with its own stall pattern.
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        t_cipher_out want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (cipher_queue.size() == 0) begin
                    $error("result_hi: unexpected result %h", out_if.data[127:64]);
                    err_cnt++;
                end else begin
                    want = cipher_queue.pop_front();
                    if (out_if.data[127:64] !== want.hi) begin
                        $error("result_hi: expected %h, got %h", want.hi, out_if.data[127:64]);
                        err_cnt++;
                    end
                    if (out_if.data[63:0] !== want.lo) begin
                        $error("result_lo: expected %h, got %h", want.lo, out_if.data[63:0]);
                        err_cnt++;
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(8, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= $urandom_range(0, 1);
                default: out_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("[aes128_block_cipher_core] ERROR");
                $finish;
            end
        end
    end

    task automatic write_key_reg(input logic idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == 1'(REG_KEY_HIGH)) cur_key[127:64] = val;
        else cur_key[63:0] = val;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_key(input logic [127:0] key);
        write_key_reg(1'(REG_KEY_HIGH), key[127:64]);
        write_key_reg(1'(REG_KEY_LOW), key[63:0]);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic drain;
        while (block_queue.size() > 0 || cipher_queue.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo);
        t_item it;
        it.dec = dec;
        it.data = {hi, lo};
        block_queue.push_back(it);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom} & {$urandom, $urandom};
            3: return {$urandom, $urandom} | {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
        end
    endtask

    task automatic queue_corners;
        queue_block(CMD_ENC, '0, '0);
        queue_block(CMD_DEC, '0, '0);
        queue_block(CMD_ENC, '1, '1);
        queue_block(CMD_DEC, '1, '1);
        queue_block(CMD_ENC, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        queue_block(CMD_DEC, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = 1'(REG_KEY_HIGH);
        cfg_if.wdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Key left at its reset value of zero.
        queue_corners();
        drain();

        load_key(128'h0001_0203_0405_0607_0809_0a0b_0c0d_0e0f);
        queue_block(CMD_ENC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        queue_block(CMD_DEC, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
        queue_corners();
        drain();

        load_key('1);
        queue_corners();
        drain();

        load_key(128'h2b7e_1516_28ae_d2a6_abf7_1588_09cf_4f3c);
        queue_block(CMD_ENC, 64'h3243_f6a8_885a_308d, 64'h3131_98a2_e037_0734);
        queue_block(CMD_DEC, 64'h3925_841d_02dc_09fb, 64'hdc11_8597_196a_0b32);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            load_key({rand_word(), rand_word()});
            queue_random(240);
            drain();
        end

        if (err_cnt == 0) begin
            $display("[aes128_block_cipher_core] OK");
        end else begin
            $display("[aes128_block_cipher_core] ERROR");
        end
        $finish;
    end
endmodule
